// ----- hdl/mtpc_pkg.sv -----
// Muon threshold pass counter: shared widths, register codes, item type, helpers.
// No dependencies; compile first.
`timescale 1ns / 1ps
package mtpc_pkg;

  localparam int NUM_THRESHOLDS = 4;
  localparam int NUM_REPORTED   = 4;

  localparam int PT_W   = 16;
  localparam int ETA_W  = 14;
  localparam int THR_W  = 16;
  localparam int HIT_W  = 2;
  localparam int REQ_W  = 2;
  localparam int CNT_W  = 32;
  localparam int MASK_W = NUM_REPORTED;

  localparam int REG_W  = 32;
  localparam int ADDR_W = 5;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_REQUIRED = 3'd0;
  localparam logic [IDX_W-1:0] REG_THR_A    = 3'd1;
  localparam logic [IDX_W-1:0] REG_THR_B    = 3'd2;
  localparam logic [IDX_W-1:0] REG_THR_C    = 3'd3;
  localparam logic [IDX_W-1:0] REG_THR_D    = 3'd4;

  localparam logic [REQ_W-1:0] REQUIRED_RESET = 2'd1;
  localparam logic [HIT_W-1:0] HIT_MAX        = 2'd2;

  // |eta| < 2.4 in 1/1024 units
  localparam logic signed [ETA_W-1:0] ETA_LIMIT_POS = 14'sd2457;
  localparam logic signed [ETA_W-1:0] ETA_LIMIT_NEG = -14'sd2457;

  typedef struct packed {
    logic                    present;
    logic [PT_W-1:0]         pt;
    logic signed [ETA_W-1:0] eta;
    logic                    fired;
    logic                    last;
  } mtpc_item_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

endpackage

// ----- hdl/mtpc_if.sv -----
// Muon threshold pass counter: candidate and result channel interfaces.
// Depends on mtpc_pkg.
`timescale 1ns / 1ps
interface mtpc_in_if;
  import mtpc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    muon_present;
  logic [PT_W-1:0]         muon_pt;
  logic signed [ETA_W-1:0] muon_eta;
  logic                    trigger_fired;
  logic                    last_of_event;

  modport source (
    output valid, muon_present, muon_pt, muon_eta, trigger_fired, last_of_event,
    input  ready
  );
  modport sink (
    input  valid, muon_present, muon_pt, muon_eta, trigger_fired, last_of_event,
    output ready
  );
endinterface

interface mtpc_out_if;
  import mtpc_pkg::*;

  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] pass_mask;
  logic [CNT_W-1:0]  total_events;
  logic [CNT_W-1:0]  passes_a;
  logic [CNT_W-1:0]  passes_b;
  logic [CNT_W-1:0]  passes_c;
  logic [CNT_W-1:0]  passes_d;

  modport source (
    output valid, pass_mask, total_events, passes_a, passes_b, passes_c, passes_d,
    input  ready
  );
  modport sink (
    input  valid, pass_mask, total_events, passes_a, passes_b, passes_c, passes_d,
    output ready
  );
endinterface

// ----- hdl/muon_threshold_pass_counter.sv -----
// Muon threshold pass counter top level: input register, per-threshold count logic,
// result register and APB register file. Depends on mtpc_pkg and mtpc_if.
//
// Takes one muon candidate per clock. A candidate is captured in an input register
// and processed from there by one compare-and-count slice per threshold; an
// end-of-event transaction then loads the result register, so its result passes
// through the input and result registers. Sustained rate is one candidate per cycle,
// set by the compare and saturating-add path; the input only stalls when an
// end-of-event candidate waits for a result that has not yet been taken. The
// reported counters are live registers that change only when a new result loads.
// Registers: 0 required_muons, 1..4 thresholds a..d, at byte address 4*index.
`timescale 1ns / 1ps
module muon_threshold_pass_counter (
  input  logic                        clk,
  input  logic                        rst_n,
  mtpc_in_if.sink                     in_ch,
  mtpc_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mtpc_pkg::ADDR_W-1:0] paddr,
  input  logic [mtpc_pkg::REG_W-1:0]  pwdata,
  output logic [mtpc_pkg::REG_W-1:0]  prdata,
  output logic                        pready
);
  import mtpc_pkg::*;

  logic [REQ_W-1:0]  req_r;
  logic [THR_W-1:0]  thr_r [NUM_THRESHOLDS];
  logic [HIT_W-1:0]  hit_r [NUM_THRESHOLDS];
  logic [HIT_W-1:0]  hit_nxt [NUM_THRESHOLDS];
  logic [CNT_W-1:0]  cnt_r [NUM_THRESHOLDS];
  logic [CNT_W-1:0]  total_r;
  logic [NUM_THRESHOLDS-1:0] pass;

  logic              s1_valid_r;
  mtpc_item_t        s1_r;
  logic              s1_adv;
  logic              s1_end;
  logic              in_acc;
  logic              eta_ok;

  logic              out_valid_r;
  logic [MASK_W-1:0] mask_r;
  logic [MASK_W-1:0] mask_nxt;
  logic [CNT_W-1:0]  rep_cnt [NUM_REPORTED];
  logic [THR_W-1:0]  rep_thr [NUM_REPORTED];

  logic              cfg_wr;
  logic [IDX_W-1:0]  cfg_idx;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r <= REQUIRED_RESET;
      for (int i = 0; i < NUM_THRESHOLDS; i++) begin
        thr_r[i] <= '0;
      end
    end else if (cfg_wr) begin
      if (cfg_idx == REG_REQUIRED) begin
        req_r <= pwdata[REQ_W-1:0];
      end
      for (int i = 0; i < NUM_THRESHOLDS; i++) begin
        if (i < NUM_REPORTED && int'(cfg_idx) == int'(REG_THR_A) + i) begin
          thr_r[i] <= pwdata[THR_W-1:0];
        end
      end
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_REQUIRED: prdata = REG_W'(req_r);
      REG_THR_A:    prdata = REG_W'(rep_thr[0]);
      REG_THR_B:    prdata = REG_W'(rep_thr[1]);
      REG_THR_C:    prdata = REG_W'(rep_thr[2]);
      REG_THR_D:    prdata = REG_W'(rep_thr[3]);
      default:      prdata = '0;
    endcase
  end

  // Input register
  assign s1_end      = s1_valid_r && s1_r.last;
  assign s1_adv      = s1_valid_r && (!s1_r.last || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc || (s1_valid_r && !s1_adv);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r.present <= in_ch.muon_present;
      s1_r.pt      <= in_ch.muon_pt;
      s1_r.eta     <= in_ch.muon_eta;
      s1_r.fired   <= in_ch.trigger_fired;
      s1_r.last    <= in_ch.last_of_event;
    end
  end

  // Per-threshold hit counting
  assign eta_ok = s1_r.present && (s1_r.eta >= ETA_LIMIT_NEG) && (s1_r.eta <= ETA_LIMIT_POS);

  always_comb begin
    for (int i = 0; i < NUM_THRESHOLDS; i++) begin
      if (eta_ok && s1_r.pt >= thr_r[i] && hit_r[i] < HIT_MAX) begin
        hit_nxt[i] = hit_r[i] + HIT_W'(1);
      end else begin
        hit_nxt[i] = hit_r[i];
      end
      pass[i] = s1_r.fired && (hit_nxt[i] >= req_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      for (int i = 0; i < NUM_THRESHOLDS; i++) begin
        hit_r[i] <= '0;
        cnt_r[i] <= '0;
      end
    end else if (s1_adv) begin
      if (s1_r.last) begin
        total_r <= sat_inc(total_r);
        for (int i = 0; i < NUM_THRESHOLDS; i++) begin
          hit_r[i] <= '0;
          if (pass[i]) begin
            cnt_r[i] <= sat_inc(cnt_r[i]);
          end
        end
      end else begin
        for (int i = 0; i < NUM_THRESHOLDS; i++) begin
          hit_r[i] <= hit_nxt[i];
        end
      end
    end
  end

  // Reported thresholds and counters
  for (genvar g = 0; g < NUM_REPORTED; g++) begin : g_rep
    if (g < NUM_THRESHOLDS) begin : g_on
      assign mask_nxt[g] = pass[g];
      assign rep_cnt[g]  = cnt_r[g];
      assign rep_thr[g]  = thr_r[g];
    end else begin : g_off
      assign mask_nxt[g] = 1'b0;
      assign rep_cnt[g]  = '0;
      assign rep_thr[g]  = '0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (s1_adv && s1_r.last) || (out_valid_r && !out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_r.last) begin
      mask_r <= mask_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pass_mask    = mask_r;
  assign out_ch.total_events = total_r;
  assign out_ch.passes_a     = rep_cnt[0];
  assign out_ch.passes_b     = rep_cnt[1];
  assign out_ch.passes_c     = rep_cnt[2];
  assign out_ch.passes_d     = rep_cnt[3];

  // Assertions
  a_end_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_end |=> out_valid_r)
    else $error("end-of-event transaction did not load the result register");

  a_total_only_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_adv && s1_end) |=> $stable(total_r))
    else $error("event total changed without an end-of-event transaction");

  a_total_steps_by_one: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_end && total_r != {CNT_W{1'b1}} |=> total_r == $past(total_r) + CNT_W'(1))
    else $error("event total did not advance by one");

  for (genvar g = 0; g < NUM_THRESHOLDS; g++) begin : g_chk
    a_hit_bounded: assert property (@(posedge clk) disable iff (!rst_n)
      hit_r[g] <= HIT_MAX)
      else $error("hit count exceeded its saturation limit");
  end

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for muon_threshold_pass_counter: directed event cases, then
// random event streams under several register settings and idle/stall patterns.
// Depends on mtpc_pkg, mtpc_if and the muon_threshold_pass_counter RTL.
`timescale 1ns / 1ps
module tb_top;
  import mtpc_pkg::*;

  localparam int ETA_CUT         = 2457;
  localparam logic [HIT_W-1:0] HIT_CAP = 2'd2;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 156;
  localparam int DRAIN_CYCLES    = 8;
  localparam int TIMEOUT_NS      = 2_000_000;
  localparam logic [NUM_THRESHOLDS-1:0][THR_W-1:0] LADDER =
    {16'hFFFF, 16'd1000, 16'd100, 16'd0};

  typedef struct packed {
    logic [MASK_W-1:0]                     mask;
    logic [CNT_W-1:0]                      total;
    logic [NUM_REPORTED-1:0][CNT_W-1:0]    passes;
  } event_tally_t;

  logic clk = 1'b0;
  logic rst_n;

  mtpc_in_if  in_ch ();
  mtpc_out_if out_ch ();

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [REG_W-1:0]  pwdata;
  logic [REG_W-1:0]  prdata;
  logic              pready;

  muon_threshold_pass_counter dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // register mirror and event state
  logic [REQ_W-1:0]                  req_m;
  logic [THR_W-1:0]                  thr_m [NUM_THRESHOLDS];
  logic [HIT_W-1:0]                  hit_cnt [NUM_THRESHOLDS];
  logic [CNT_W-1:0]                  pass_cnt [NUM_THRESHOLDS];
  logic [CNT_W-1:0]                  event_cnt;
  event_tally_t                      expected_tallies [$];

  int send_idle_pct;
  int recv_stall_pct;
  int fail_count;
  int items_sent;
  int results_seen;
  int reg_writes;

  event_tally_t got_tally;
  event_tally_t want_tally;

  function automatic void report_mismatch(input string what, input logic [63:0] want,
                                          input logic [63:0] got);
    $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, what, want, got);
    fail_count++;
  endfunction

  function automatic mtpc_item_t muon(input logic present, input logic [PT_W-1:0] pt,
                                      input logic signed [ETA_W-1:0] eta,
                                      input logic fired, input logic last);
    muon = '{present, pt, eta, fired, last};
  endfunction

  // Advance the event state by one candidate; queue the tally at end of event.
  function automatic void tally_candidate(input mtpc_item_t it);
    int           abs_eta;
    event_tally_t t;
    abs_eta = it.eta;
    if (abs_eta < 0) abs_eta = -abs_eta;
    if (it.present && abs_eta <= ETA_CUT) begin
      for (int i = 0; i < NUM_THRESHOLDS; i++) begin
        if (it.pt >= thr_m[i] && hit_cnt[i] < HIT_CAP) hit_cnt[i] = hit_cnt[i] + 1'b1;
      end
    end
    if (!it.last) return;
    if (event_cnt != '1) event_cnt = event_cnt + 1'b1;
    t = '0;
    t.total = event_cnt;
    for (int i = 0; i < NUM_THRESHOLDS; i++) begin
      if (it.fired && hit_cnt[i] >= req_m) begin
        if (pass_cnt[i] != '1) pass_cnt[i] = pass_cnt[i] + 1'b1;
        t.mask[i] = 1'b1;
      end
      hit_cnt[i] = '0;
      t.passes[i] = pass_cnt[i];
    end
    expected_tallies.push_back(t);
  endfunction

  task automatic send_muon(input mtpc_item_t it);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.muon_present  <= it.present;
    in_ch.muon_pt       <= it.pt;
    in_ch.muon_eta      <= it.eta;
    in_ch.trigger_fired <= it.fired;
    in_ch.last_of_event <= it.last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tally_candidate(it);
    items_sent++;
  endtask

  // Drop valid, wait for every pending result, then let the pipeline empty.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_tallies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One setup + access transaction; bus is left selected for a back-to-back access.
  task automatic reg_access(input logic [IDX_W-1:0] idx, input logic wr,
                            input logic [REG_W-1:0] data, output logic [REG_W-1:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    if (wr) begin
      if (idx == REG_REQUIRED) begin
        req_m = data[REQ_W-1:0];
      end else if (idx >= REG_THR_A && idx <= REG_THR_D) begin
        thr_m[idx - REG_THR_A] = data[THR_W-1:0];
      end
    end
  endtask

  task automatic check_regs();
    logic [REG_W-1:0] rd;
    logic [REG_W-1:0] want;
    for (int r = REG_REQUIRED; r <= REG_THR_D; r++) begin
      reg_access(IDX_W'(r), 1'b0, '0, rd);
      if (r == REG_REQUIRED) want = REG_W'(req_m);
      else want = REG_W'(thr_m[r - REG_THR_A]);
      if (rd !== want)
        report_mismatch($sformatf("register %0d readback", r), 64'(want), 64'(rd));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write every register with junk in the unused upper bits, then read back.
  task automatic program_regs(input logic [REQ_W-1:0] req,
                              input logic [NUM_THRESHOLDS-1:0][THR_W-1:0] thr);
    logic [REG_W-1:0] data;
    logic [REG_W-1:0] scratch;
    data = $urandom;
    data[REQ_W-1:0] = req;
    reg_access(REG_REQUIRED, 1'b1, data, scratch);
    for (int i = 0; i < NUM_THRESHOLDS; i++) begin
      data = $urandom;
      data[THR_W-1:0] = thr[i];
      reg_access(REG_THR_A + IDX_W'(i), 1'b1, data, scratch);
    end
    reg_writes += NUM_THRESHOLDS + 1;
    check_regs();
  endtask

  // result checker and receiver stall
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      got_tally.mask   = out_ch.pass_mask;
      got_tally.total  = out_ch.total_events;
      got_tally.passes = {out_ch.passes_d, out_ch.passes_c, out_ch.passes_b, out_ch.passes_a};
      if (expected_tallies.size() == 0) begin
        $display("%0t: result transaction with nothing expected, actual mask 0x%0h total %0d",
                 $time, got_tally.mask, got_tally.total);
        fail_count++;
      end else begin
        want_tally = expected_tallies.pop_front();
        if (got_tally.mask !== want_tally.mask)
          report_mismatch("pass_mask", 64'(want_tally.mask), 64'(got_tally.mask));
        if (got_tally.total !== want_tally.total)
          report_mismatch("total_events", 64'(want_tally.total), 64'(got_tally.total));
        for (int i = 0; i < NUM_REPORTED; i++) begin
          if (got_tally.passes[i] !== want_tally.passes[i])
            report_mismatch($sformatf("passes[%0d]", i), 64'(want_tally.passes[i]),
                            64'(got_tally.passes[i]));
        end
      end
    end
  end

  task automatic test_register_reset();
    check_regs();
  endtask

  task automatic test_empty_marker();
    send_muon(muon(1'b0, 16'hFFFF, 14'sd0, 1'b1, 1'b1));
    send_muon(muon(1'b0, 16'hFFFF, 14'sd0, 1'b1, 1'b0));
    send_muon(muon(1'b1, 16'h0000, 14'sd0, 1'b1, 1'b1));
  endtask

  task automatic test_field_extremes();
    settle();
    program_regs(2'd1, LADDER);
    send_muon(muon(1'b1, 16'hFFFF, 14'sd8191, 1'b1, 1'b1));
    send_muon(muon(1'b1, 16'hFFFF, 14'sh2000, 1'b1, 1'b1));
    send_muon(muon(1'b1, 16'hFFFF, 14'sd0, 1'b1, 1'b1));
    send_muon(muon(1'b1, 16'h0000, 14'sd0, 1'b1, 1'b1));
  endtask

  task automatic test_eta_window();
    send_muon(muon(1'b1, 16'd1000, 14'sd2457, 1'b1, 1'b1));
    send_muon(muon(1'b1, 16'd1000, -14'sd2457, 1'b1, 1'b1));
    send_muon(muon(1'b1, 16'd1000, 14'sd2458, 1'b1, 1'b1));
    send_muon(muon(1'b1, 16'd1000, -14'sd2458, 1'b1, 1'b1));
  endtask

  task automatic test_trigger_off();
    send_muon(muon(1'b1, 16'hFFFF, 14'sd0, 1'b0, 1'b1));
    send_muon(muon(1'b1, 16'hFFFF, 14'sd0, 1'b1, 1'b0));
    send_muon(muon(1'b0, 16'h0000, 14'sd0, 1'b0, 1'b1));
  endtask

  task automatic test_required_modes();
    settle();
    program_regs(2'd2, LADDER);
    send_muon(muon(1'b1, 16'd200, 14'sd0, 1'b0, 1'b0));
    send_muon(muon(1'b1, 16'd200, -14'sd100, 1'b0, 1'b0));
    send_muon(muon(1'b1, 16'd200, 14'sd100, 1'b1, 1'b1));
    send_muon(muon(1'b1, 16'hFFFF, 14'sd0, 1'b1, 1'b1));
    settle();
    program_regs(2'd0, LADDER);
    send_muon(muon(1'b0, 16'h0000, 14'sd0, 1'b1, 1'b1));
    settle();
    program_regs(2'd3, LADDER);
    send_muon(muon(1'b1, 16'hFFFF, 14'sd0, 1'b1, 1'b0));
    send_muon(muon(1'b1, 16'hFFFF, 14'sd0, 1'b1, 1'b0));
    send_muon(muon(1'b1, 16'hFFFF, 14'sd0, 1'b1, 1'b1));
    settle();
    program_regs(2'd1, LADDER);
  endtask

  task automatic test_unknown_register();
    logic [REG_W-1:0] scratch;
    for (int r = REG_THR_D + 1; r < (1 << IDX_W); r++) begin
      reg_access(IDX_W'(r), 1'b1, $urandom, scratch);
      reg_writes++;
    end
    check_regs();
    send_muon(muon(1'b1, 16'd150, 14'sd0, 1'b1, 1'b1));
  endtask

  task automatic test_random_traffic();
    logic [REQ_W-1:0]                     req;
    logic [NUM_THRESHOLDS-1:0][THR_W-1:0] thr;
    logic [PT_W-1:0]                      pt;
    logic signed [ETA_W-1:0]              eta;
    logic                                 fired;
    int                                   sent;
    int                                   len;
    int                                   pick;
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      case (p)
        4: req = 2'd0;
        6: req = 2'd3;
        default: req = (p % 2) ? 2'd2 : 2'd1;
      endcase
      for (int i = 0; i < NUM_THRESHOLDS; i++) begin
        pick = $urandom_range(5);
        if (p == 0 || pick == 0) thr[i] = '0;
        else if (p == 1 || pick == 1) thr[i] = '1;
        else thr[i] = THR_W'($urandom_range(4000));
      end
      program_regs(req, thr);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if ($urandom_range(9) == 0) begin
          // unstructured transaction: any field, any end flag
          send_muon(muon(1'($urandom_range(1)), PT_W'($urandom), ETA_W'($urandom),
                         1'($urandom_range(1)), 1'($urandom_range(1))));
          sent++;
        end else begin
          len   = $urandom_range(1, 5);
          fired = ($urandom_range(3) != 0);
          for (int k = 0; k < len; k++) begin
            pick = $urandom_range(5);
            if (pick == 0) pt = PT_W'($urandom);
            else if (pick == 1) pt = $urandom_range(1) ? '1 : '0;
            else pt = thr_m[$urandom_range(NUM_THRESHOLDS - 1)] - 1'b1
                      + PT_W'($urandom_range(2));
            pick = $urandom_range(7);
            if (pick == 0) eta = ETA_W'($urandom);
            else if (pick == 1) eta = ETA_W'(($urandom_range(1) ? 1 : -1)
                                             * (ETA_CUT + int'($urandom_range(1))));
            else eta = ETA_W'(int'($urandom_range(2 * ETA_CUT)) - ETA_CUT);
            send_muon(muon($urandom_range(9) != 0, pt, eta,
                           (k == len - 1) ? fired : logic'($urandom_range(1)),
                           k == len - 1));
            sent++;
          end
        end
      end
    end
  endtask

  initial begin
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.muon_present  <= 1'b0;
    in_ch.muon_pt       <= '0;
    in_ch.muon_eta      <= '0;
    in_ch.trigger_fired <= 1'b0;
    in_ch.last_of_event <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fail_count     = 0;
    items_sent     = 0;
    results_seen   = 0;
    reg_writes     = 0;
    req_m          = REQUIRED_RESET;
    event_cnt      = '0;
    for (int i = 0; i < NUM_THRESHOLDS; i++) begin
      thr_m[i]    = '0;
      hit_cnt[i]  = '0;
      pass_cnt[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_reset();
    test_empty_marker();
    test_field_extremes();
    test_eta_window();
    test_trigger_off();
    test_required_modes();
    test_unknown_register();
    test_random_traffic();
    settle();

    $display("Covered %0d candidate transactions, %0d event results, %0d register writes",
             items_sent, results_seen, reg_writes);
    $display("across %0d random settings with idle and stall patterns on both channels",
             NUM_PHASES);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d results still pending", expected_tallies.size());
    $display("tb_top failed");
    $finish;
  end

endmodule
